/* src/interval_coverage_tracker_core_defines.svh */
// ----------------------------------------------------------------------------
// interval_coverage_tracker_core_defines
// Assertion macros for the tracker RTL.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_COVERAGE_TRACKER_CORE_DEFINES_SVH
`define INTERVAL_COVERAGE_TRACKER_CORE_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle.
`define ICT_ASSERT_IMP(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed");
// Assert that a condition implies a consequence in the next cycle.
`define ICT_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed");
`endif

/* src/ict_pkg.sv */
// ----------------------------------------------------------------------------
// ict_pkg
// Shared constants and types for the interval coverage tracker.
// ----------------------------------------------------------------------------
package ict_pkg;
  localparam int MaxBoundaries = 64;
  localparam int AddrWidth = 32;
  localparam int IdxWidth = $clog2(MaxBoundaries);
  localparam int CntWidth = $clog2(MaxBoundaries + 1);

  typedef logic [AddrWidth-1:0] addr_t;
  typedef logic [IdxWidth-1:0] idx_t;
  typedef logic [CntWidth-1:0] cnt_t;

  localparam logic [1:0] OpInsert = 2'd0;
  localparam logic [1:0] OpQuery = 2'd1;
  localparam logic [1:0] OpLowest = 2'd2;
  localparam logic [1:0] OpInvalid = 2'd3;

  localparam logic CfgRangeStart = 1'b0;
  localparam logic CfgRangeStop = 1'b1;

  typedef struct packed {
    logic [1:0] operation;
    addr_t      insert_start;
    addr_t      insert_stop;
    addr_t      query_address;
  } in_word_t;

  typedef struct packed {
    logic  failed;
    logic  in_empty;
    addr_t next_boundary;
    addr_t empty_start;
    addr_t empty_stop;
  } out_word_t;
endpackage

/* src/ict_stream_if.sv */
// ----------------------------------------------------------------------------
// ict_stream_if
// Valid/ready channel carrying one word of type word_t.
// ----------------------------------------------------------------------------
interface ict_stream_if #(parameter type word_t = logic);
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/interval_coverage_tracker_core.sv */
// ----------------------------------------------------------------------------
// interval_coverage_tracker_core
// Sorted boundary table in a one-port-read synchronous memory; operations
// run as a sequencer that scans, then shifts entries to insert or remove.
// ----------------------------------------------------------------------------
// A bad operation gets its result straight from the idle state; otherwise the
// scan reads the boundary memory one entry at a time (S_SCAN issues the
// address, S_EVAL compares) to locate the segment, and an insert that opens a
// gap then moves the tail of the table one entry at a time (S_SHRD reads,
// S_SHWR writes) before one or two puts (S_PUT) and a final state (S_DONE).
// A new word is accepted only while the core is idle and the previous result
// has been taken. A range register write reinitializes the table; no word is
// accepted until that is done. Results are held in an output register until
// taken.
`include "interval_coverage_tracker_core_defines.svh"
module interval_coverage_tracker_core
  import ict_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic [0:0]    cfg_index,
  input  addr_t         cfg_data,
  ict_stream_if.sink    in_port,
  ict_stream_if.source  out_port
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_EVAL  = 7'b0000100,
    S_SHRD  = 7'b0001000,
    S_SHWR  = 7'b0010000,
    S_PUT   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t   state;
  addr_t    mem [MaxBoundaries];
  addr_t    rd_data;
  idx_t     rd_addr;
  logic     wr_en;
  idx_t     wr_addr;
  addr_t    wr_data;

  cnt_t     count;
  logic     first_full;
  addr_t    range_start;
  addr_t    range_stop;
  in_word_t cur;
  cnt_t     k;         // index of the entry being read this cycle
  addr_t    prev;      // b[k-1]
  logic     have_prev;
  // shift control
  logic     shift_up;  // 1: open a gap, 0: close a gap
  cnt_t     sh_pos;    // current position in the shift
  cnt_t     sh_end;
  addr_t    put_val;
  addr_t    put_val2;
  logic     put_two;
  cnt_t     put_at;
  logic     del_two;
  out_word_t res;
  logic     out_valid;
  logic     init_pend;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  assign in_port.ready = (state == S_IDLE) && !out_valid && !init_pend;
  assign out_port.valid = out_valid;
  assign out_port.data = res;

  // Scan compare key: address for query, start for insert.
  addr_t key;
  assign key = (cur.operation == OpQuery) ? cur.query_address : cur.insert_start;

  // Segment data after the scan: seg i = [prev, rd_data) with index k-1.
  cnt_t  seg_i;
  logic  seg_empty;
  assign seg_i = k - cnt_t'(1);
  assign seg_empty = (first_full ^ seg_i[0]) == 1'b0;

  always_comb begin
    rd_addr = idx_t'(0);
    wr_en = 1'b0;
    wr_addr = idx_t'(0);
    wr_data = '0;
    if (init_pend) begin
      wr_en = 1'b1;
      wr_addr = idx_t'(0);
      wr_data = range_start;
    end
    unique case (state)
      S_IDLE: rd_addr = idx_t'(0);
      S_SCAN: rd_addr = k[IdxWidth-1:0];
      S_EVAL: rd_addr = k[IdxWidth-1:0];
      S_SHRD: rd_addr = sh_pos[IdxWidth-1:0];
      S_SHWR: begin
        rd_addr = sh_pos[IdxWidth-1:0];
        wr_en = 1'b1;
        wr_addr = shift_up ? (sh_pos[IdxWidth-1:0] + idx_t'(put_two ? 2 : 1))
                           : (sh_pos[IdxWidth-1:0] - idx_t'(del_two ? 2 : 1));
        wr_data = rd_data;
      end
      S_PUT: begin
        wr_en = 1'b1;
        wr_addr = put_at[IdxWidth-1:0];
        wr_data = put_val;
      end
      S_DONE: rd_addr = idx_t'(0);
      default: rd_addr = idx_t'(0);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      count <= cnt_t'(2);
      first_full <= 1'b0;
      range_start <= '0;
      range_stop <= '1;
      init_pend <= 1'b1;
    end else begin
      if (out_port.valid && out_port.ready) out_valid <= 1'b0;
      if (cfg_write) begin
        if (cfg_index == CfgRangeStart) range_start <= cfg_data;
        else range_stop <= cfg_data;
        count <= cnt_t'(2);
        first_full <= 1'b0;
        init_pend <= 1'b1;
        state <= S_IDLE;
      end else if (init_pend) begin
        // Second init write goes through the put path.
        init_pend <= 1'b0;
        state <= S_PUT;
        put_at <= cnt_t'(1);
        put_val <= range_stop;
        put_two <= 1'b0;
        cur.operation <= OpInvalid;
      end else begin
        unique case (state)
          S_IDLE: begin
            if (in_port.valid && in_port.ready) begin
              cur <= in_port.data;
              res <= '0;
              k <= '0;
              have_prev <= 1'b0;
              if (in_port.data.operation == OpLowest) begin
                k <= first_full ? cnt_t'(1) : cnt_t'(0);
                state <= S_SCAN;
              end else if (in_port.data.operation == OpInvalid) begin
                res.failed <= 1'b1;
                out_valid <= 1'b1;
              end else begin
                state <= S_SCAN;
              end
            end
          end
          S_SCAN: begin
            // Issue read of b[k]; data arrives in S_EVAL.
            state <= S_EVAL;
          end
          S_EVAL: begin
            if (cur.operation == OpLowest) begin
              if (!have_prev) begin
                prev <= rd_data;
                have_prev <= 1'b1;
                k <= k + cnt_t'(1);
                state <= S_SCAN;
              end else begin
                if (k < count && prev < rd_data) begin
                  res.empty_start <= prev;
                  res.empty_stop <= rd_data;
                end else begin
                  res.failed <= 1'b1;
                end
                out_valid <= 1'b1;
                state <= S_IDLE;
              end
            end else if (k < count && key >= rd_data) begin
              prev <= rd_data;
              have_prev <= 1'b1;
              k <= k + cnt_t'(1);
              state <= S_SCAN;
            end else if (cur.operation == OpQuery) begin
              if (k < count) begin
                res.next_boundary <= rd_data;
                res.in_empty <= have_prev && seg_empty;
              end
              out_valid <= 1'b1;
              state <= S_IDLE;
            end else begin
              // Insert: segment i = k-1, lo = prev, hi = rd_data.
              state <= S_IDLE;
              out_valid <= 1'b1;
              if (cur.insert_stop <= cur.insert_start || !have_prev || k >= count
                  || !seg_empty || cur.insert_stop > rd_data) begin
                res.failed <= 1'b1;
              end else if (cur.insert_start > prev && cur.insert_stop < rd_data) begin
                if (count + cnt_t'(2) > cnt_t'(MaxBoundaries) || count > cnt_t'(MaxBoundaries-2)) begin
                  res.failed <= 1'b1;
                end else begin
                  out_valid <= 1'b0;
                  shift_up <= 1'b1; put_two <= 1'b1; del_two <= 1'b0;
                  sh_pos <= count - cnt_t'(1); sh_end <= k;
                  put_at <= k; put_val <= cur.insert_start;
                  put_val2 <= cur.insert_stop;
                  count <= count + cnt_t'(2);
                  state <= S_SHRD;
                end
              end else if (cur.insert_start == prev && cur.insert_stop < rd_data) begin
                if (seg_i != '0) begin
                  out_valid <= 1'b0;
                  put_two <= 1'b0; put_at <= seg_i; put_val <= cur.insert_stop;
                  state <= S_PUT;
                end else if (count >= cnt_t'(MaxBoundaries)) begin
                  res.failed <= 1'b1;
                end else begin
                  out_valid <= 1'b0;
                  first_full <= 1'b1;
                  shift_up <= 1'b1; put_two <= 1'b0; del_two <= 1'b0;
                  sh_pos <= count - cnt_t'(1); sh_end <= cnt_t'(1);
                  put_at <= cnt_t'(1); put_val <= cur.insert_stop;
                  count <= count + cnt_t'(1);
                  state <= S_SHRD;
                end
              end else if (cur.insert_start > prev) begin
                if (k != count - cnt_t'(1)) begin
                  out_valid <= 1'b0;
                  put_two <= 1'b0; put_at <= k; put_val <= cur.insert_start;
                  state <= S_PUT;
                end else if (count >= cnt_t'(MaxBoundaries)) begin
                  res.failed <= 1'b1;
                end else begin
                  out_valid <= 1'b0;
                  shift_up <= 1'b1; put_two <= 1'b0; del_two <= 1'b0;
                  sh_pos <= count - cnt_t'(1); sh_end <= k;
                  put_at <= k; put_val <= cur.insert_start;
                  count <= count + cnt_t'(1);
                  state <= S_SHRD;
                end
              end else begin
                // Whole segment fills: drop boundaries that separated it.
                if (seg_i == '0) first_full <= 1'b1;
                if (k != count - cnt_t'(1)) begin
                  out_valid <= 1'b0;
                  shift_up <= 1'b0; put_two <= 1'b0;
                  del_two <= (seg_i != '0);
                  sh_pos <= k + cnt_t'(1); sh_end <= count;
                  count <= count - ((seg_i != '0) ? cnt_t'(2) : cnt_t'(1));
                  state <= S_SHRD;
                end else if (seg_i != '0) begin
                  // Last segment: drop b[i] by moving range_stop down.
                  out_valid <= 1'b0;
                  shift_up <= 1'b0; put_two <= 1'b0; del_two <= 1'b0;
                  sh_pos <= k; sh_end <= count;
                  count <= count - cnt_t'(1);
                  state <= S_SHRD;
                end
              end
            end
          end
          S_SHRD: begin
            if (shift_up ? (sh_pos < sh_end) : (sh_pos >= sh_end)) begin
              state <= shift_up ? S_PUT : S_DONE;
            end else begin
              state <= S_SHWR;
            end
          end
          S_SHWR: begin
            sh_pos <= shift_up ? sh_pos - cnt_t'(1) : sh_pos + cnt_t'(1);
            state <= S_SHRD;
          end
          S_PUT: begin
            if (put_two) begin
              put_two <= 1'b0;
              put_at <= put_at + cnt_t'(1);
              put_val <= put_val2;
            end else begin
              state <= S_DONE;
            end
          end
          S_DONE: begin
            if (cur.operation != OpInvalid) out_valid <= 1'b1;
            state <= S_IDLE;
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  `ICT_ASSERT_IMP(a_ready_idle, in_port.ready, state == S_IDLE)
  `ICT_ASSERT_IMP(a_count_range, 1'b1, count >= cnt_t'(2) && count <= cnt_t'(MaxBoundaries))
  `ICT_ASSERT_NEXT(a_busy_after_accept, in_port.valid && in_port.ready && !cfg_write,
                   !in_port.ready)
endmodule

/* tb/ict_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ict_tb_pkg
// Wait and hold-off limits for the tracker testbench.
// ----------------------------------------------------------------------------
package ict_tb_pkg;
  import ict_pkg::*;
  localparam int MaxWait = 16;
  localparam int LongHold = 400;
endpackage

/* tb/ict_coverage_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ict_coverage_checker
// Watches the tracker channels, keeps its own boundary table and compares
// every result word with the predicted one.
// ----------------------------------------------------------------------------
module ict_coverage_checker
  import ict_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_write,
  input  logic      cfg_index,
  input  addr_t     cfg_data,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_word_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_word_t out_data,
  output int        error_count,
  output int        pending_count,
  output int        result_count,
  output int        insert_ok_count
);
  addr_t     bounds [MaxBoundaries];
  int        bound_cnt;
  logic      lead_full;
  addr_t     span_lo, span_hi;
  out_word_t expected_words [$];

  task automatic clear_table();
    foreach (bounds[k]) bounds[k] = '0;
    bounds[0] = span_lo;
    bounds[1] = span_hi;
    bound_cnt = 2;
    lead_full = 1'b0;
  endtask

  function automatic void shift_in(int pos, addr_t v);
    for (int k = bound_cnt; k > pos; k--) bounds[k] = bounds[k-1];
    bounds[pos] = v;
    bound_cnt++;
  endfunction

  function automatic void shift_out(int pos);
    for (int k = pos; k < bound_cnt - 1; k++) bounds[k] = bounds[k+1];
    bound_cnt--;
    bounds[bound_cnt] = '0;
  endfunction

  function automatic logic mark_full(addr_t s, addr_t e);
    int i;
    addr_t lo, hi;
    logic last;
    i = 0;
    if (e <= s) return 1'b1;
    while (i + 1 < bound_cnt && s >= bounds[i+1]) i++;
    if (i + 1 >= bound_cnt) return 1'b1;
    if ((lead_full ^ i[0]) != 1'b0) return 1'b1;
    lo = bounds[i];
    hi = bounds[i+1];
    last = (i + 1 == bound_cnt - 1);
    if (s < lo || e > hi) return 1'b1;
    if (s > lo && e < hi) begin
      if (bound_cnt + 2 > MaxBoundaries) return 1'b1;
      shift_in(i + 1, e);
      shift_in(i + 1, s);
    end else if (s == lo && e < hi) begin
      if (i > 0) begin
        bounds[i] = e;
      end else begin
        if (bound_cnt + 1 > MaxBoundaries) return 1'b1;
        shift_in(1, e);
        lead_full = 1'b1;
      end
    end else if (s > lo) begin
      if (!last) begin
        bounds[i+1] = s;
      end else begin
        if (bound_cnt + 1 > MaxBoundaries) return 1'b1;
        shift_in(i + 1, s);
      end
    end else begin
      if (!last) shift_out(i + 1);
      if (i > 0) shift_out(i);
      else lead_full = 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic out_word_t predict_coverage(in_word_t w);
    out_word_t r;
    int k;
    int j;
    r = '0;
    case (w.operation)
      OpInsert: begin
        r.failed = mark_full(w.insert_start, w.insert_stop);
      end
      OpQuery: begin
        k = 0;
        while (k < bound_cnt && w.query_address >= bounds[k]) k++;
        if (k < bound_cnt) begin
          r.next_boundary = bounds[k];
          if (k >= 1 && (lead_full ^ (k - 1) % 2) == 0) r.in_empty = 1'b1;
        end
      end
      OpLowest: begin
        j = lead_full ? 1 : 0;
        if (j + 1 < bound_cnt && bounds[j] < bounds[j+1]) begin
          r.empty_start = bounds[j];
          r.empty_stop = bounds[j+1];
        end else begin
          r.failed = 1'b1;
        end
      end
      default: r.failed = 1'b1;
    endcase
    return r;
  endfunction

  assign pending_count = expected_words.size();

  always @(posedge clk) begin
    out_word_t e;
    if (rst) begin
      span_lo = '0;
      span_hi = '1;
      clear_table();
      expected_words.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == CfgRangeStart) span_lo = cfg_data;
        else span_hi = cfg_data;
        clear_table();
      end
      if (in_valid && in_ready) begin
        e = predict_coverage(in_data);
        if (in_data.operation == OpInsert && !e.failed) insert_ok_count++;
        expected_words.push_back(e);
      end
      if (out_valid && out_ready) begin
        result_count++;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, out_data);
          error_count++;
        end else begin
          e = expected_words.pop_front();
          if (e !== out_data) begin
            $display("%0t: mismatch expected f=%b e=%b nb=%h es=%h ee=%h", $time,
                     e.failed, e.in_empty, e.next_boundary, e.empty_start, e.empty_stop);
            $display("%0t:          actual   f=%b e=%b nb=%h es=%h ee=%h", $time,
                     out_data.failed, out_data.in_empty, out_data.next_boundary,
                     out_data.empty_start, out_data.empty_stop);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    error_count = 0;
    result_count = 0;
    insert_ok_count = 0;
  end
endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Interval coverage tracker test: directed edge cases, then random phases of
// well-formed fills, queries and noise over several tracked ranges.
// ----------------------------------------------------------------------------
module tb;
  import ict_pkg::*;
  import ict_tb_pkg::*;

  logic  clk;
  logic  rst;
  logic  cfg_write;
  logic  cfg_index;
  addr_t cfg_data;
  int    error_count, pending_count, result_count, insert_ok_count;
  int    words_sent;
  logic  hold_long;
  addr_t lo_addr, hi_addr;

  ict_stream_if #(.word_t(in_word_t))  in_ch ();
  ict_stream_if #(.word_t(out_word_t)) out_ch ();

  interval_coverage_tracker_core dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_port(in_ch.sink), .out_port(out_ch.source)
  );

  ict_coverage_checker checker_i (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_data(in_ch.data), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_data(out_ch.data), .error_count(error_count), .pending_count(pending_count),
    .result_count(result_count), .insert_ok_count(insert_ok_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #80ms;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off while the sender waits.
  initial begin
    int w;
    out_ch.ready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (hold_long) begin
        out_ch.ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MaxWait);
      if (w > 0) begin
        out_ch.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk iff out_ch.valid);
    end
  end

  task automatic send_word(logic [1:0] op, addr_t s, addr_t e, addr_t q);
    int w;
    w = (words_sent % 200 < 40) ? 0 : $urandom_range(0, MaxWait);
    if (w > 0) begin
      in_ch.valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= '{operation: op, insert_start: s, insert_stop: e, query_address: q};
    @(posedge clk iff in_ch.ready);
    words_sent++;
  endtask

  task automatic write_range(addr_t s, addr_t e);
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_write <= 1'b1; cfg_index <= CfgRangeStart; cfg_data <= s;
    @(posedge clk);
    cfg_index <= CfgRangeStop; cfg_data <= e;
    @(posedge clk);
    cfg_write <= 1'b0;
    repeat (4) @(posedge clk);
    lo_addr = s;
    hi_addr = e;
  endtask

  function automatic addr_t pick_addr();
    addr_t span;
    span = hi_addr - lo_addr;
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return lo_addr;
      2: return hi_addr;
      default: return (span == 0) ? lo_addr : lo_addr + ($urandom() % span);
    endcase
  endfunction

  // Mostly fills, many of small empty-looking ranges, so the table gets deep.
  task automatic random_phase(int count);
    addr_t a, b;
    for (int n = 0; n < count; n++) begin
      a = pick_addr();
      b = a + $urandom_range(1, 2000);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_word(OpInsert, a, b, $urandom());
        4: send_word(OpInsert, $urandom(), $urandom(), $urandom());
        5, 6: send_word(OpQuery, $urandom(), $urandom(), pick_addr());
        7: send_word(OpLowest, $urandom(), $urandom(), $urandom());
        8: send_word(OpInvalid, $urandom(), $urandom(), $urandom());
        default: send_word(OpInsert, lo_addr, hi_addr, a);
      endcase
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CfgRangeStart;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    hold_long = 1'b0;
    words_sent = 0;
    lo_addr = '0;
    hi_addr = '1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset range, edges, split, extend, merge, overlap, bad op.
    send_word(OpLowest, '0, '0, '0);
    send_word(OpQuery, '0, '0, '0);
    send_word(OpQuery, '0, '0, '1);
    send_word(OpInsert, 32'd10, 32'd10, '0);
    send_word(OpInsert, 32'd20, 32'd10, '0);
    send_word(OpInsert, 32'd100, 32'd200, '0);
    send_word(OpInsert, 32'd150, 32'd160, '0);
    send_word(OpInsert, 32'd200, 32'd300, '0);
    send_word(OpInsert, 32'd50, 32'd100, '0);
    send_word(OpInsert, 32'd0, 32'd20, '0);
    send_word(OpInsert, 32'd20, 32'd50, '0);
    send_word(OpQuery, '0, '0, 32'd300);
    send_word(OpQuery, '0, '0, 32'd299);
    send_word(OpLowest, '0, '0, '0);
    send_word(OpInsert, 32'hFFFF_FF00, '1, '0);
    send_word(OpInsert, 32'd300, 32'hFFFF_FF00, '0);
    send_word(OpLowest, '0, '0, '0);
    send_word(OpInvalid, '1, '1, '1);
    write_range(32'd1000, 32'd1000);
    send_word(OpInsert, 32'd1000, 32'd1001, '0);
    send_word(OpQuery, '0, '0, 32'd999);
    send_word(OpLowest, '0, '0, '0);
    write_range(32'h8000_0000, 32'h7FFF_FFFF);
    send_word(OpQuery, '0, '0, 32'h7FFF_FFFF);
    send_word(OpLowest, '0, '0, '0);

    write_range(32'd0, 32'd20000);
    random_phase(200);
    // Long receiver hold-off while the sender keeps offering words.
    fork
      begin
        hold_long = 1'b1;
        repeat (LongHold) @(posedge clk);
        hold_long = 1'b0;
      end
      random_phase(40);
    join
    write_range(32'h1234_0000, 32'h1234_4000);
    random_phase(200);
    write_range(32'hFFFF_0000, '1);
    random_phase(150);
    write_range($urandom(), $urandom());
    random_phase(60);
    write_range('0, '1);
    random_phase(150);

    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Sent %0d words, checked %0d results, %0d fills accepted.",
             words_sent, result_count, insert_ok_count);
    $display("Ranges covered reset, degenerate, small, top-of-space and random.");
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
